// ===== design/aht_pkg.sv =====
// Shared constants and types for the averaging hysteresis thermostat.
// Holds register indexes, reset values, field widths and the
// controller/datapath command and status bundles. No dependencies.
package aht_pkg;

  // Default build-time sizes
  localparam int SPR_DEFAULT = 10;
  localparam int WINDOW_DEPTH_DEFAULT = 8;

  // Fixed field widths
  localparam int ADC_BITS = 10;
  localparam int TS_W = 32;
  localparam int TEMP_W = 11;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 11'd2047;

  // Conversion: sum * CONV_MUL / (64 * samples per reading)
  localparam int CONV_MUL_W = 7;
  localparam logic [CONV_MUL_W-1:0] CONV_MUL = 7'd110;
  localparam int CONV_SHIFT = 6;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LEN_W = 4;
  localparam int GAP_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_TH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIM  = 3'd5;

  localparam logic [TEMP_W-1:0] START_TH_RST = 11'd400;
  localparam logic [TEMP_W-1:0] STOP_TH_RST  = 11'd480;
  localparam logic [LEN_W-1:0]  WIN_LEN_RST  = 4'd5;
  localparam logic [GAP_W-1:0]  GAP_LIM_RST  = 16'd5000;

  // Stream payload widths
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 16;

  typedef struct packed {
    logic take;        // accept one input beat into the burst
    logic conv_start;  // register the scaled burst sum
    logic conv_latch;  // capture converted temperature
    logic win_write;   // push into the window, arm the read sweep
    logic sum_run;     // step the window read sweep
    logic avg_start;   // launch window-average division
    logic avg_latch;   // capture averaged temperature on divider done
    logic decide;      // run hysteresis, load output register
  } aht_cmd_t;

  typedef struct packed {
    logic burst_last;  // next accepted sample completes the burst
    logic avg_en;      // averaging enabled
    logic div_done;    // divider finished this cycle
    logic sum_done;    // window sweep complete
    logic out_free;    // output register can take a beat
  } aht_status_t;

endpackage

// ===== design/aht_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses no package items; instantiated by aht_datapath.
module aht_div #(
  parameter int N = 15,
  parameter int D = 5
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic [N-1:0] quotient,
  output logic         done
);

  localparam int CNT_W = $clog2(N + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [N-1:0]     q;
  logic [D-1:0]     rem;
  logic [D-1:0]     dvs;
  logic [D:0]       trial;
  logic [D:0]       diff;
  logic             ge;
  logic [D-1:0]     rem_next;

  always_comb begin
    trial = {rem, q[N-1]};
    ge = trial >= {1'b0, dvs};
    diff = trial - {1'b0, dvs};
    rem_next = ge ? diff[D-1:0] : trial[D-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      q <= {q[N-2:0], ge};
    end
  end

  assign quotient = q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with empty count");
`endif

endmodule

// ===== design/aht_datapath.sv =====
// Datapath: burst accumulator, conversion, averaging window, hysteresis
// and output register. Depends on aht_pkg and aht_div.
module aht_datapath
  import aht_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SPR_DEFAULT,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  aht_cmd_t              cmd,
  output aht_status_t           status,
  input  logic [S_DATA_W-1:0]   s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SPR = SAMPLES_PER_READING;
  localparam int WD = WINDOW_DEPTH;
  localparam int SUM_W = $clog2(SPR * ((1 << ADC_BITS) - 1) + 1);
  localparam int CNT_W = $clog2(SPR + 1);
  localparam int PROD_W = SUM_W + CONV_MUL_W;
  localparam int CONV_W = PROD_W - CONV_SHIFT;
  localparam int ACC_W = $clog2(WD * 2047 + 1);
  localparam int DIV_W = ACC_W;
  localparam int FILL_W = $clog2(WD + 1);
  localparam int HEAD_W = (WD > 1) ? $clog2(WD) : 1;
  localparam int DVS_W = FILL_W;
  // Divide by the burst length as a multiply by its rounded-up reciprocal;
  // the extra fraction bits keep the quotient exact over the full range.
  localparam int RECIP_SHIFT = CONV_W + 5;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SHIFT) + SPR - 1) / SPR);
  localparam int RPROD_W = CONV_W + RECIP_W;
  localparam int CQ_W = RPROD_W - RECIP_SHIFT;

  // Configuration registers
  logic [TEMP_W-1:0] start_th;
  logic [TEMP_W-1:0] stop_th;
  logic              cooling;
  logic              avg_en;
  logic [LEN_W-1:0]  win_len;
  logic [GAP_W-1:0]  gap_lim;

  logic [SUM_W-1:0]  burst_sum;
  logic [CNT_W-1:0]  burst_count;
  logic [SUM_W-1:0]  burst_total;
  logic [TS_W-1:0]   reading_ts;
  logic [TEMP_W-1:0] temp;
  logic              run_flag;

  logic [TEMP_W-1:0] win_mem [WD];
  logic [FILL_W-1:0] win_fill;
  logic [HEAD_W-1:0] win_head;
  logic [TS_W-1:0]   last_ms;

  logic [HEAD_W-1:0] rd_idx;
  logic [FILL_W-1:0] rd_left;
  logic              rd_valid;
  logic [TEMP_W-1:0] rd_data;
  logic [ACC_W-1:0]  acc;
  logic [FILL_W-1:0] use_q;

  logic [ADC_BITS-1:0] sample;
  logic [TS_W-1:0]     sample_ts;
  logic [SUM_W-1:0]    total;
  logic [PROD_W-1:0]   prod;
  logic [CONV_W-1:0]   conv_y;
  logic [RPROD_W-1:0]  rprod;
  logic [CQ_W-1:0]     conv_q;
  logic [TS_W-1:0]     gap;
  logic                gap_hit;
  logic [FILL_W-1:0]   fill_base;
  logic [HEAD_W-1:0]   head_base;
  logic [FILL_W-1:0]   fill_next;
  logic [HEAD_W-1:0]   head_next;
  logic [LEN_W:0]      len_sat;
  logic [FILL_W-1:0]   len_fw;
  logic [FILL_W-1:0]   use_n;
  logic [HEAD_W-1:0]   rd_idx_next;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic [DIV_W-1:0]  div_quot;
  logic              div_done;
  logic [TEMP_W-1:0] conv_temp;

  logic              run_next;
  logic              switch_now;

  assign sample = s_tdata[ADC_BITS-1:0];
  assign sample_ts = s_tdata[ADC_BITS +: TS_W];
  assign total = burst_sum + SUM_W'(sample);
  assign prod = PROD_W'(burst_total) * PROD_W'(CONV_MUL);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_th <= START_TH_RST;
      stop_th <= STOP_TH_RST;
      cooling <= 1'b0;
      avg_en <= 1'b0;
      win_len <= WIN_LEN_RST;
      gap_lim <= GAP_LIM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_TH: start_th <= cfg_data[TEMP_W-1:0];
        REG_STOP_TH:  stop_th <= cfg_data[TEMP_W-1:0];
        REG_COOLING:  cooling <= cfg_data[0];
        REG_AVG_EN:   avg_en <= cfg_data[0];
        REG_WIN_LEN:  win_len <= cfg_data[LEN_W-1:0];
        REG_GAP_LIM:  gap_lim <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Burst accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_sum <= '0;
      burst_count <= '0;
    end else if (cmd.take) begin
      if (status.burst_last) begin
        burst_sum <= '0;
        burst_count <= '0;
      end else begin
        burst_sum <= total;
        burst_count <= burst_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && status.burst_last) begin
      burst_total <= total;
      reading_ts <= sample_ts;
    end
  end

  // Conversion: scale and drop the fraction, then divide by the burst length
  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      conv_y <= prod[PROD_W-1:CONV_SHIFT];
    end
  end

  assign rprod = RPROD_W'(conv_y) * RPROD_W'(RECIP);
  assign conv_q = rprod[RPROD_W-1:RECIP_SHIFT];
  assign conv_temp = (conv_q > CQ_W'(TEMP_MAX)) ? TEMP_MAX : conv_q[TEMP_W-1:0];

  // Divider for the window average
  assign div_start = cmd.avg_start;
  assign div_dividend = DIV_W'(acc);
  assign div_divisor = DVS_W'(use_q);

  aht_div #(
    .N(DIV_W),
    .D(DVS_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_dividend),
    .divisor(div_divisor),
    .quotient(div_quot),
    .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.conv_latch) begin
      temp <= conv_temp;
    end else if (div_done && cmd.avg_latch) begin
      temp <= div_quot[TEMP_W-1:0];
    end
  end

  // Window bookkeeping
  always_comb begin
    gap = reading_ts - last_ms;
    gap_hit = gap > TS_W'(gap_lim);
    fill_base = gap_hit ? '0 : win_fill;
    head_base = gap_hit ? '0 : win_head;
    fill_next = (fill_base < FILL_W'(WD)) ? fill_base + 1'b1 : fill_base;
    head_next = (head_base == HEAD_W'(WD - 1)) ? '0 : head_base + 1'b1;
    if (win_len == '0) begin
      len_sat = (LEN_W + 1)'(1);
    end else if ({1'b0, win_len} > (LEN_W + 1)'(WD)) begin
      len_sat = (LEN_W + 1)'(WD);
    end else begin
      len_sat = {1'b0, win_len};
    end
    len_fw = FILL_W'(len_sat);
    use_n = (fill_next < len_fw) ? fill_next : len_fw;
    rd_idx_next = (rd_idx == '0) ? HEAD_W'(WD - 1) : rd_idx - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_fill <= '0;
      win_head <= '0;
      last_ms <= '0;
      rd_left <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.win_write) begin
      win_fill <= fill_next;
      win_head <= head_next;
      last_ms <= reading_ts;
      rd_left <= use_n;
      rd_valid <= 1'b0;
    end else if (cmd.sum_run) begin
      rd_valid <= rd_left != '0;
      if (rd_left != '0) begin
        rd_left <= rd_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_write) begin
      win_mem[head_base] <= temp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_run && rd_left != '0) begin
      rd_data <= win_mem[rd_idx];
    end
  end

  // Sweep newest to oldest and accumulate
  always_ff @(posedge clk) begin
    if (cmd.win_write) begin
      rd_idx <= head_base;
      acc <= '0;
      use_q <= use_n;
    end else if (cmd.sum_run) begin
      if (rd_left != '0) begin
        rd_idx <= rd_idx_next;
      end
      if (rd_valid) begin
        acc <= acc + ACC_W'(rd_data);
      end
    end
  end

  // Hysteresis and output register
  always_comb begin
    if (!run_flag) begin
      switch_now = cooling ? (temp >= start_th) : (temp <= start_th);
    end else begin
      switch_now = cooling ? (temp <= stop_th) : (temp >= stop_th);
    end
    run_next = run_flag ^ switch_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (cmd.decide) begin
      run_flag <= run_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      m_tdata <= M_DATA_W'({switch_now, run_next, temp});
    end
  end

  always_comb begin
    status.burst_last = burst_count == CNT_W'(SPR - 1);
    status.avg_en = avg_en;
    status.div_done = div_done;
    status.sum_done = (rd_left == '0) && !rd_valid;
    status.out_free = !m_tvalid || m_tready;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    win_fill <= FILL_W'(WD))
    else $error("window fill beyond depth");
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    rd_left <= win_fill)
    else $error("window sweep longer than fill");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> m_tvalid && (m_tdata[TEMP_W] == run_flag))
    else $error("result beat not presented with run state");
`endif

endmodule

// ===== design/aht_ctrl.sv =====
// Controller state machine sequencing burst, conversion, window and decision.
// Depends on aht_pkg for the command and status bundles.
module aht_ctrl
  import aht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  aht_status_t status,
  output aht_cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_CONV_GO   = 8'b0000_0010,
    ST_CONV_WAIT = 8'b0000_0100,
    ST_WIN_WR    = 8'b0000_1000,
    ST_SUM       = 8'b0001_0000,
    ST_AVG_GO    = 8'b0010_0000,
    ST_AVG_WAIT  = 8'b0100_0000,
    ST_DECIDE    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.take = s_tvalid;
        if (s_tvalid && status.burst_last) begin
          state_next = ST_CONV_GO;
        end
      end
      ST_CONV_GO: begin
        cmd.conv_start = 1'b1;
        state_next = ST_CONV_WAIT;
      end
      ST_CONV_WAIT: begin
        cmd.conv_latch = 1'b1;
        state_next = status.avg_en ? ST_WIN_WR : ST_DECIDE;
      end
      ST_WIN_WR: begin
        cmd.win_write = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_run = 1'b1;
        if (status.sum_done) begin
          state_next = ST_AVG_GO;
        end
      end
      ST_AVG_GO: begin
        cmd.avg_start = 1'b1;
        state_next = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        cmd.avg_latch = 1'b1;
        if (status.div_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.out_free) begin
          cmd.decide = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/averaging_hysteresis_thermostat.sv =====
// Top level of the averaging hysteresis thermostat.
// Depends on aht_pkg, aht_ctrl and aht_datapath (which holds aht_div).
//
// Raw sensor samples enter one per beat; every SAMPLES_PER_READING-th sample
// closes a burst and yields one result beat (temperature in 1/16 degree, run
// state, changed flag), all other samples yield nothing. No new sample is
// taken while a closing sample is converted, averaged and decided; without
// averaging the conversion leads straight to the decision. The burst
// conversion is a constant scale followed by a multiply with the reciprocal
// of the burst length, registered in between, while a restoring divider
// DIV_W bits wide (14 bits at the default sizes) producing one quotient bit
// per cycle forms the window average, and the window is read one entry per
// cycle from its memory. The output is registered, so new samples are taken
// while a result beat waits; a second reading waits only if the first is
// still not taken. The window memory needs no clearing after reset. Write
// configuration only while no reading is in progress.
module averaging_hysteresis_thermostat
  import aht_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SPR_DEFAULT,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Sample stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // [9:0] adc_sample, [41:10] timestamp_ms, rest zero
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // [10:0] temperature, [11] running, [12] changed
  // Register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  aht_cmd_t    cmd;
  aht_status_t status;

  // Sequence each reading: accumulate, convert, window, decide
  aht_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status(status),
    .cmd(cmd)
  );

  // Hold all arithmetic, storage, registers and the result beat
  aht_datapath #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING),
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

endmodule
